// ----- design/cbear_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbear_pkg
// Shared constants for the compass bearing pipeline: default sizes, fixed
// point formats and the arctangent table of the rotation stages.
// ----------------------------------------------------------------------------
package cbear_pkg;

  localparam int CoordWidthDefault     = 32;
  localparam int RotationStagesDefault = 20;

  // magnitudes are normalized so the larger one has its top bit here
  localparam int NormBit = 29;

  // rotation datapath widths
  localparam int XyWidth    = 33;
  localparam int AngleWidth = 25;
  localparam int TableWidth = 22;
  localparam int BearWidth  = 16;

  // angles in units of 2^-16 degree
  localparam logic [AngleWidth-1:0] Deg90  = AngleWidth'(90 * 65536);
  localparam logic [AngleWidth-1:0] Deg180 = AngleWidth'(180 * 65536);
  localparam logic [AngleWidth-1:0] Deg360 = AngleWidth'(360 * 65536);
  localparam logic [AngleWidth-1:0] RoundHalf = AngleWidth'(256);
  localparam int RoundShift = 9;

  // output codes in units of 1/128 degree
  localparam logic [BearWidth-1:0] BearFull     = BearWidth'(46080);
  localparam logic [BearWidth-1:0] BearCoincide = BearWidth'(34560);

  // atan(2^-i) in units of 2^-16 degree, rounded to nearest
  localparam logic [TableWidth-1:0] AtanTable [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0
  };

endpackage

// ----- design/compass_bearing_between_points_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_bearing_between_points_top
// Compass bearing from a start point to a target point, north 0, clockwise,
// in 1/128 degree, computed by a pipelined vectoring rotation.
// ----------------------------------------------------------------------------
// A new point pair is taken on every clock edge with start_i high; busy_o
// never rises. Each pair produces one bearing on bearing_o, marked by a
// one-cycle done_o pulse, in the order the pairs came in. A pair passes
// through the input register, then register stages for the difference,
// magnitude, leading-one search and normalizing shift, the unrolled rotation
// stages, one register stage each, and stages for clamp and quadrant
// placement, rounding and wrap. There is no backpressure: the receiver must
// take each word in the cycle it is shown.
module compass_bearing_between_points_top
  import cbear_pkg::*;
#(
  parameter int COORD_WIDTH     = CoordWidthDefault,
  parameter int ROTATION_STAGES = RotationStagesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] from_x_i,
  input  logic signed [COORD_WIDTH-1:0] from_y_i,
  input  logic signed [COORD_WIDTH-1:0] to_x_i,
  input  logic signed [COORD_WIDTH-1:0] to_y_i,
  output logic                          done_o,
  output logic        [BearWidth-1:0]   bearing_o
);

  localparam int Cw   = COORD_WIDTH;
  localparam int Dw   = COORD_WIDTH + 1;
  localparam int MsbW = $clog2(Dw);
  localparam int Ew   = Dw + NormBit + 1;
  localparam int Rs   = ROTATION_STAGES;

  assign busy_o = 1'b0;

  // ---------------- input register ----------------
  logic                 v0_q;
  logic signed [Cw-1:0] fx_q, fy_q, tx_q, ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q <= from_x_i;
    fy_q <= from_y_i;
    tx_q <= to_x_i;
    ty_q <= to_y_i;
  end

  // ---------------- differences ----------------
  logic                 v1_q;
  logic signed [Dw-1:0] east_d, north_d, east_q, north_q;

  assign east_d  = $signed({tx_q[Cw-1], tx_q}) - $signed({fx_q[Cw-1], fx_q});
  assign north_d = $signed({ty_q[Cw-1], ty_q}) - $signed({fy_q[Cw-1], fy_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    east_q  <= east_d;
    north_q <= north_d;
  end

  // ---------------- magnitudes ----------------
  logic          v2_q, eneg2_q, nneg2_q;
  logic [Dw-1:0] emag2_q, nmag2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    eneg2_q <= east_q[Dw-1];
    nneg2_q <= north_q[Dw-1];
    emag2_q <= east_q[Dw-1] ? Dw'(-east_q) : Dw'(east_q);
    nmag2_q <= north_q[Dw-1] ? Dw'(-north_q) : Dw'(north_q);
  end

  // ---------------- leading-one search ----------------
  // the top set bit of the larger magnitude is the top set bit of the or
  logic            v3_q, eneg3_q, nneg3_q, zero3_q, right3_q;
  logic [Dw-1:0]   emag3_q, nmag3_q, both_or;
  logic [MsbW-1:0] msb_d;
  logic [MsbW:0]   msb_ext, amt_d;
  logic [MsbW:0]   amt3_q;
  logic            right_d;

  assign both_or = emag2_q | nmag2_q;

  always_comb begin
    msb_d = '0;
    for (int k = 0; k < Dw; k++) begin
      if (both_or[k]) begin
        msb_d = MsbW'(k);
      end
    end
  end

  assign msb_ext = {1'b0, msb_d};
  assign right_d = (msb_ext > (MsbW+1)'(NormBit));
  assign amt_d   = right_d ? (msb_ext - (MsbW+1)'(NormBit))
                           : ((MsbW+1)'(NormBit) - msb_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    eneg3_q  <= eneg2_q;
    nneg3_q  <= nneg2_q;
    zero3_q  <= (both_or == '0);
    right3_q <= right_d;
    amt3_q   <= amt_d;
    emag3_q  <= emag2_q;
    nmag3_q  <= nmag2_q;
  end

  // ---------------- normalizing shift ----------------
  // right shift floors, left shift is exact
  logic [Ew-1:0]    eext, next, eshift, nshift;

  assign eext   = Ew'(emag3_q);
  assign next   = Ew'(nmag3_q);
  assign eshift = right3_q ? (eext >> amt3_q) : (eext << amt3_q);
  assign nshift = right3_q ? (next >> amt3_q) : (next << amt3_q);

  // rotation pipeline, index 0 is the normalized start vector
  logic                         cv_q    [Rs+1];
  logic                         ceneg_q [Rs+1];
  logic                         cnneg_q [Rs+1];
  logic                         czero_q [Rs+1];
  logic signed [XyWidth-1:0]    cx_q    [Rs+1];
  logic signed [XyWidth-1:0]    cy_q    [Rs+1];
  logic signed [AngleWidth-1:0] cz_q    [Rs+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ceneg_q[0] <= eneg3_q;
    cnneg_q[0] <= nneg3_q;
    czero_q[0] <= zero3_q;
    cx_q[0]    <= $signed(XyWidth'(nshift[NormBit:0]));
    cy_q[0]    <= $signed(XyWidth'(eshift[NormBit:0]));
    cz_q[0]    <= '0;
  end

  // ---------------- rotation stages ----------------
  for (genvar g = 0; g < Rs; g++) begin : g_rot
    localparam logic [XyWidth-1:0] LowMask = (XyWidth'(1) << g) - XyWidth'(1);
    localparam logic signed [AngleWidth-1:0] StepAngle =
      $signed(AngleWidth'(AtanTable[g]));

    logic signed [XyWidth-1:0]    xs, ys, x_d, y_d;
    logic signed [AngleWidth-1:0] z_d;
    logic                         ys_fix;

    // x never goes negative, so only y needs the round-toward-zero fix
    assign ys_fix = cy_q[g][XyWidth-1] && ((cy_q[g] & LowMask) != '0);
    assign xs     = cx_q[g] >>> g;
    assign ys     = (cy_q[g] >>> g) + $signed(XyWidth'(ys_fix));

    always_comb begin
      if (!cy_q[g][XyWidth-1]) begin
        x_d = cx_q[g] + ys;
        y_d = cy_q[g] - xs;
        z_d = cz_q[g] + StepAngle;
      end else begin
        x_d = cx_q[g] - ys;
        y_d = cy_q[g] + xs;
        z_d = cz_q[g] - StepAngle;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[g+1] <= 1'b0;
      end else begin
        cv_q[g+1] <= cv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      ceneg_q[g+1] <= ceneg_q[g];
      cnneg_q[g+1] <= cnneg_q[g];
      czero_q[g+1] <= czero_q[g];
      cx_q[g+1]    <= x_d;
      cy_q[g+1]    <= y_d;
      cz_q[g+1]    <= z_d;
    end
  end

  // ---------------- clamp and quadrant placement ----------------
  logic                  vq_q, zeroq_q;
  logic [AngleWidth-1:0] quad, total_d, total_q;

  always_comb begin
    if (cz_q[Rs][AngleWidth-1]) begin
      quad = '0;
    end else if (cz_q[Rs] > $signed(Deg90)) begin
      quad = Deg90;
    end else begin
      quad = AngleWidth'(cz_q[Rs]);
    end
  end

  always_comb begin
    unique case ({cnneg_q[Rs], ceneg_q[Rs]})
      2'b00:   total_d = quad;
      2'b10:   total_d = Deg180 - quad;
      2'b11:   total_d = Deg180 + quad;
      default: total_d = Deg360 - quad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= 1'b0;
    end else begin
      vq_q <= cv_q[Rs];
    end
  end

  always_ff @(posedge clk_i) begin
    zeroq_q <= czero_q[Rs];
    total_q <= total_d;
  end

  // ---------------- rounding ----------------
  logic                 vr_q, zeror_q;
  logic [AngleWidth:0]  rounded;
  logic [BearWidth-1:0] round_q;

  assign rounded = {1'b0, total_q} + {1'b0, RoundHalf};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else begin
      vr_q <= vq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zeror_q <= zeroq_q;
    round_q <= rounded[RoundShift +: BearWidth];
  end

  // ---------------- wrap and output ----------------
  logic                 done_q;
  logic [BearWidth-1:0] bear_d, bear_q;

  always_comb begin
    priority if (zeror_q) begin
      bear_d = BearCoincide;
    end else if (round_q >= BearFull) begin
      bear_d = round_q - BearFull;
    end else begin
      bear_d = round_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bear_q <= bear_d;
  end

  assign done_o    = done_q;
  assign bearing_o = bear_q;

endmodule
